### rtl/cc20_pkg.sv
package cc20_pkg;

   // ChaCha20 block function
   localparam int DOUBLE_ROUNDS = 10;
   localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
   localparam int HALF_W        = $clog2(HALF_ROUNDS);

   localparam int BLOCK_BYTES = 64;
   localparam int POS_W       = 7;
   localparam int SEL_W       = 6;
   localparam int STATE_BITS  = 512;

   // "expand 32-byte k", word 0 in the low slot
   localparam logic [3:0][31:0] SIGMA = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   // 16-word cipher state, [row][column]; word i sits at [i/4][i%4]
   typedef logic [3:0][3:0][31:0] word16_type;

   typedef enum logic [2:0] {
      CSR_KEY_PART_0   = 3'd0,
      CSR_KEY_PART_1   = 3'd1,
      CSR_KEY_PART_2   = 3'd2,
      CSR_KEY_PART_3   = 3'd3,
      CSR_NONCE_LOW    = 3'd4,
      CSR_NONCE_HIGH   = 3'd5,
      CSR_INIT_COUNTER = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   typedef enum logic {
      ST_IDLE,
      ST_GEN
   } top_state_type;

   typedef struct packed {
      logic             start;
      logic [SEL_W-1:0] rd_sel;
   } core_ctrl_type;

   typedef struct packed {
      logic       done;
      logic [7:0] ks_byte;
   } core_stat_type;

endpackage

### rtl/cc20_qr_unit.sv
// One quarter-round step: sum = x + y, mix = rotl(z ^ sum, r(step)).
module cc20_qr_unit (
   input  logic [31:0] op_x,
   input  logic [31:0] op_y,
   input  logic [31:0] op_z,
   input  logic [1:0]  step,
   output logic [31:0] sum,
   output logic [31:0] mix
);

   logic [31:0] t;

   always_comb begin
      sum = op_x + op_y;
      t   = op_z ^ sum;
      case (step)
         2'd0:    mix = {t[15:0], t[31:16]};
         2'd1:    mix = {t[19:0], t[31:20]};
         2'd2:    mix = {t[23:0], t[31:24]};
         default: mix = {t[24:0], t[31:25]};
      endcase
   end

endmodule

### rtl/cc20_core.sv
// Block generator: one quarter-round step per cycle on fixed taps.
// Rows rotate left one word after each quarter round, so the active column
// (or diagonal) always lines up with the taps. Add-back shifts the whole state.
module cc20_core (
   input  logic                      clock,
   input  logic                      reset,
   input  cc20_pkg::core_ctrl_type   ctrl,
   input  cc20_pkg::word16_type      init_words,
   output cc20_pkg::core_stat_type   stat
);

   cc20_pkg::core_state_type       state_ff, state_in;
   cc20_pkg::word16_type           w_ff, w_in, w_upd;
   logic [3:0]                     cnt_ff, cnt_in;
   logic [cc20_pkg::HALF_W-1:0]    half_ff, half_in;
   logic                           done_ff, done_in;
   logic                           diag;
   logic [31:0]                    tap_a, tap_b, tap_c, tap_d;
   logic [31:0]                    op_x, op_y, op_z, sum, mix;
   logic [cc20_pkg::STATE_BITS-1:0] w_flat;
   logic [31:0]                    rd_word;
   logic [3:0][7:0]                rd_bytes;

   cc20_qr_unit u_qr (
      .op_x (op_x),
      .op_y (op_y),
      .op_z (op_z),
      .step (cnt_ff[1:0]),
      .sum  (sum),
      .mix  (mix)
   );

   // taps: column round uses column 0, diagonal round uses the main diagonal
   always_comb begin
      diag  = half_ff[0];
      tap_a = w_ff[0][0];
      tap_b = diag ? w_ff[1][1] : w_ff[1][0];
      tap_c = diag ? w_ff[2][2] : w_ff[2][0];
      tap_d = diag ? w_ff[3][3] : w_ff[3][0];
      w_flat = w_ff;

      if (state_ff == cc20_pkg::CORE_ADD) begin
         op_x = w_ff[0][0];
         op_y = init_words[cnt_ff[3:2]][cnt_ff[1:0]];
         op_z = w_ff[0][0];
      end else if (!cnt_ff[0]) begin
         op_x = tap_a;
         op_y = tap_b;
         op_z = tap_d;
      end else begin
         op_x = tap_c;
         op_y = tap_d;
         op_z = tap_b;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      half_in  = half_ff;
      done_in  = 1'b0;
      w_in     = w_ff;
      w_upd    = w_ff;

      // even steps write a and d, odd steps write c and b
      if (!cnt_ff[0]) begin
         w_upd[0][0] = sum;
         if (diag) w_upd[3][3] = mix;
         else      w_upd[3][0] = mix;
      end else begin
         if (diag) begin
            w_upd[2][2] = sum;
            w_upd[1][1] = mix;
         end else begin
            w_upd[2][0] = sum;
            w_upd[1][0] = mix;
         end
      end

      unique case (state_ff)
         cc20_pkg::CORE_IDLE: begin
            if (ctrl.start) begin
               w_in     = init_words;
               cnt_in   = '0;
               half_in  = '0;
               state_in = cc20_pkg::CORE_ROUND;
            end
         end
         cc20_pkg::CORE_ROUND: begin
            if (cnt_ff[1:0] == 2'd3) begin
               w_in[0] = {w_upd[0][0], w_upd[0][3:1]};
               w_in[1] = {w_upd[1][0], w_upd[1][3:1]};
               w_in[2] = {w_upd[2][0], w_upd[2][3:1]};
               w_in[3] = {w_upd[3][0], w_upd[3][3:1]};
            end else begin
               w_in = w_upd;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               if (half_ff == cc20_pkg::HALF_W'(cc20_pkg::HALF_ROUNDS - 1)) begin
                  state_in = cc20_pkg::CORE_ADD;
               end else begin
                  half_in = half_ff + cc20_pkg::HALF_W'(1);
               end
            end
         end
         cc20_pkg::CORE_ADD: begin
            w_in   = {sum, w_flat[cc20_pkg::STATE_BITS-1:32]};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = cc20_pkg::CORE_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = cc20_pkg::CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cc20_pkg::CORE_IDLE;
         cnt_ff   <= '0;
         half_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         half_ff  <= half_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   // keystream byte, little-endian within each word
   always_comb begin
      rd_word      = w_ff[ctrl.rd_sel[5:4]][ctrl.rd_sel[3:2]];
      rd_bytes     = rd_word;
      stat.ks_byte = rd_bytes[ctrl.rd_sel[1:0]];
      stat.done    = done_ff;
   end

endmodule

### rtl/chacha20_stream_cipher.sv
// Response: rsp_valid rises in the cycle after transaction accept while the
//   keystream block still holds bytes; when a new block is generated it waits
//   on the single add/xor/rotate unit, doing one step a cycle.
// Throughput: 1 byte per cycle if rsp_ready; every 64th byte waits for a block.
// Reset (synchronous, active high): all key/nonce/counter registers cleared,
//   keystream marked empty, no response pending.
module chacha20_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_in_message,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_out,
   // configuration writes
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cc20_pkg::top_state_type        state_ff, state_in;

   // configuration
   logic [63:0] key0_ff, key0_in, key1_ff, key1_in;
   logic [63:0] key2_ff, key2_in, key3_ff, key3_in;
   logic [63:0] nonce_low_ff, nonce_low_in;
   logic [31:0] nonce_high_ff, nonce_high_in;
   logic [31:0] init_ctr_ff, init_ctr_in;

   // stream state
   logic [31:0]                blk_ctr_ff, blk_ctr_in;
   logic [cc20_pkg::POS_W-1:0] pos_ff, pos_in;

   // transaction held while a block is generated
   logic       hold_type_ff, hold_type_in;
   logic [7:0] hold_data_ff, hold_data_in;
   logic       hold_last_ff, hold_last_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic                     req_accept;
   logic                     cfg_hit;
   cc20_pkg::word16_type     init_words;
   cc20_pkg::core_ctrl_type  core_ctrl;
   cc20_pkg::core_stat_type  core_stat;

   cc20_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (core_ctrl),
      .init_words (init_words),
      .stat       (core_stat)
   );

   // block input: constants, key, counter, nonce
   always_comb begin
      init_words[0]    = cc20_pkg::SIGMA;
      init_words[1][0] = key0_ff[31:0];
      init_words[1][1] = key0_ff[63:32];
      init_words[1][2] = key1_ff[31:0];
      init_words[1][3] = key1_ff[63:32];
      init_words[2][0] = key2_ff[31:0];
      init_words[2][1] = key2_ff[63:32];
      init_words[2][2] = key3_ff[31:0];
      init_words[2][3] = key3_ff[63:32];
      init_words[3][0] = blk_ctr_ff;
      init_words[3][1] = nonce_low_ff[31:0];
      init_words[3][2] = nonce_low_ff[63:32];
      init_words[3][3] = nonce_high_ff;
   end

   // position 64 means the keystream buffer is empty
   assign req_ready        = (state_ff == cc20_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept       = req_valid && req_ready;
   assign core_ctrl.start  = req_accept && pos_ff[cc20_pkg::POS_W-1];
   assign core_ctrl.rd_sel = pos_ff[cc20_pkg::SEL_W-1:0];

   always_comb begin
      state_in      = state_ff;
      key0_in       = key0_ff;
      key1_in       = key1_ff;
      key2_in       = key2_ff;
      key3_in       = key3_ff;
      nonce_low_in  = nonce_low_ff;
      nonce_high_in = nonce_high_ff;
      init_ctr_in   = init_ctr_ff;
      blk_ctr_in    = blk_ctr_ff;
      pos_in        = pos_ff;
      hold_type_in  = hold_type_ff;
      hold_data_in  = hold_data_ff;
      hold_last_in  = hold_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      cfg_hit       = 1'b0;

      unique case (state_ff)
         cc20_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (pos_ff[cc20_pkg::POS_W-1]) begin
                  // buffer empty: park the transaction, start a block
                  hold_type_in = req_type;
                  hold_data_in = req_data_byte;
                  hold_last_in = req_last_in_message;
                  state_in     = cc20_pkg::ST_GEN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_type ? core_stat.ks_byte
                                          : (core_stat.ks_byte ^ req_data_byte);
                  rsp_last_in  = req_last_in_message;
                  pos_in       = pos_ff + cc20_pkg::POS_W'(1);
               end
            end
         end
         cc20_pkg::ST_GEN: begin
            // rd_sel is 0 here, so ks_byte is byte 0 of the fresh block
            if (core_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_type_ff ? core_stat.ks_byte
                                           : (core_stat.ks_byte ^ hold_data_ff);
               rsp_last_in  = hold_last_ff;
               pos_in       = cc20_pkg::POS_W'(1);
               blk_ctr_in   = blk_ctr_ff + 32'd1;
               state_in     = cc20_pkg::ST_IDLE;
            end
         end
         default: state_in = cc20_pkg::ST_IDLE;
      endcase

      // config write: store, reload counter, drop buffered keystream
      if (csr_wen) begin
         cfg_hit = 1'b1;
         unique case (cc20_pkg::csr_index_type'(csr_index))
            cc20_pkg::CSR_KEY_PART_0:   key0_in       = csr_wdata;
            cc20_pkg::CSR_KEY_PART_1:   key1_in       = csr_wdata;
            cc20_pkg::CSR_KEY_PART_2:   key2_in       = csr_wdata;
            cc20_pkg::CSR_KEY_PART_3:   key3_in       = csr_wdata;
            cc20_pkg::CSR_NONCE_LOW:    nonce_low_in  = csr_wdata;
            cc20_pkg::CSR_NONCE_HIGH:   nonce_high_in = csr_wdata[31:0];
            cc20_pkg::CSR_INIT_COUNTER: init_ctr_in   = csr_wdata[31:0];
            default:                    cfg_hit       = 1'b0;
         endcase
         if (cfg_hit) begin
            blk_ctr_in = init_ctr_in;
            pos_in     = cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cc20_pkg::ST_IDLE;
         key0_ff       <= '0;
         key1_ff       <= '0;
         key2_ff       <= '0;
         key3_ff       <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         init_ctr_ff   <= '0;
         blk_ctr_ff    <= '0;
         pos_ff        <= cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key0_ff       <= key0_in;
         key1_ff       <= key1_in;
         key2_ff       <= key2_in;
         key3_ff       <= key3_in;
         nonce_low_ff  <= nonce_low_in;
         nonce_high_ff <= nonce_high_in;
         init_ctr_ff   <= init_ctr_in;
         blk_ctr_ff    <= blk_ctr_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_type_ff <= hold_type_in;
      hold_data_ff <= hold_data_in;
      hold_last_ff <= hold_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;

   // no new transaction while a block is being generated
   a_gen_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cc20_pkg::ST_GEN) |-> !req_ready)
      else $error("request accepted during block generation");

   // the core only finishes a block that was asked for
   a_done_in_gen: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> (state_ff == cc20_pkg::ST_GEN))
      else $error("block done outside generation");

   // a finished block delivers its first byte right away
   a_done_first_byte: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |=> (rsp_valid_ff && (pos_ff == cc20_pkg::POS_W'(1))))
      else $error("first keystream byte not delivered");

   // position never runs past the empty mark
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cc20_pkg::POS_W'(cc20_pkg::BLOCK_BYTES))
      else $error("keystream position out of range");

endmodule
